// ===== rtl/core/fnr_pkg.sv =====
// Shared types, codes and reset values for the fix-and-report power sequencer.
// Used by fnr_step, the top level and the port checker. No dependencies.
package fnr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_FIX_ACTIVE  = 3'd1,
    PH_WAIT_FIX    = 3'd2,
    PH_SEND_ACTIVE = 3'd3,
    PH_WAIT_REPLY  = 3'd4,
    PH_COOLDOWN    = 3'd5,
    PH_SLEEP       = 3'd6
  } phase_t;

  localparam logic [1:0] PWR_NONE    = 2'd0;
  localparam logic [1:0] PWR_ENABLE  = 2'd1;
  localparam logic [1:0] PWR_DISABLE = 2'd2;

  localparam logic [1:0] MOT_NONE        = 2'd0;
  localparam logic [1:0] MOT_INIT_LISTEN = 2'd1;
  localparam logic [1:0] MOT_LISTEN      = 2'd2;
  localparam logic [1:0] MOT_DISABLE     = 2'd3;

  localparam int CfgIndexWidth = 3;
  localparam logic [CfgIndexWidth-1:0] CFG_SLEEP_MODE   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_MOCK_PROFILE = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_FIX_TIMEOUT  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_SEND_TIMEOUT = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_COOLDOWN     = 3'd4;

  localparam logic [31:0] FIX_TIMEOUT_RESET  = 32'd120000;
  localparam logic [31:0] SEND_TIMEOUT_RESET = 32'd60000;
  localparam logic [31:0] COOLDOWN_RESET     = 32'd300000;

  typedef struct packed {
    logic        sleep_mode;
    logic        mock_profile;
    logic [31:0] fix_timeout_ms;
    logic [31:0] send_timeout_ms;
    logic [31:0] cooldown_ms;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic        fix_started;
    logic        send_started;
    logic [31:0] fix_start_stamp;
    logic [31:0] send_start_stamp;
    logic [31:0] cooldown_start_stamp;
    logic [31:0] cycle_count;
  } state_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  receiver_power;
    logic        receiver_reset;
    logic [1:0]  modem_power;
    logic        modem_reset;
    logic        load_report;
    logic [1:0]  motion_command;
    logic        apply_profile;
    logic [31:0] cycles_done;
  } result_t;

endpackage

// ===== rtl/core/fnr_step.sv =====
// Next-state and command logic for one step of the sequencer.
// Purely combinational; depends on fnr_pkg for the state, config and result types.
module fnr_step
  import fnr_pkg::*;
(
  input  cfg_t        cfg,
  input  state_t      st,
  input  logic        mode,
  input  logic [31:0] now_ms,
  input  logic        fix_ready,
  input  logic        send_done,
  input  logic        motion_wake,
  output state_t      st_next,
  output result_t     res
);

  logic        end_c;
  logic        start_c;
  logic [31:0] fix_stamp;
  logic [31:0] fix_elapsed;
  logic [31:0] send_elapsed;
  logic [31:0] cool_elapsed;

  // The fix stamp is taken on the first fix-phase step, so the timeout test
  // must see the stamp as it stands after this step.
  assign fix_stamp    = st.fix_started ? st.fix_start_stamp : now_ms;
  assign fix_elapsed  = now_ms - fix_stamp;
  assign send_elapsed = now_ms - st.send_start_stamp;
  assign cool_elapsed = now_ms - st.cooldown_start_stamp;

  always_comb begin
    st_next = st;
    res     = '0;
    end_c   = 1'b0;
    start_c = 1'b0;

    if (mode) begin
      st_next.fix_started  = 1'b0;
      st_next.send_started = 1'b0;
      if (cfg.sleep_mode) begin
        res.receiver_power = PWR_DISABLE;
        res.modem_power    = PWR_DISABLE;
        res.motion_command = MOT_INIT_LISTEN;
        st_next.phase      = PH_SLEEP;
      end else begin
        res.motion_command = MOT_DISABLE;
        start_c            = 1'b1;
      end
    end else begin
      case (st.phase)
        PH_IDLE: begin
          st_next.phase = cfg.sleep_mode ? PH_SLEEP : PH_FIX_ACTIVE;
        end
        PH_FIX_ACTIVE, PH_WAIT_FIX: begin
          st_next.fix_started     = 1'b1;
          st_next.fix_start_stamp = fix_stamp;
          if (fix_ready) begin
            // With the send latch already set the fix is ignored.
            if (!st.send_started) begin
              res.receiver_power       = PWR_DISABLE;
              res.modem_power          = PWR_ENABLE;
              res.load_report          = 1'b1;
              st_next.send_started     = 1'b1;
              st_next.phase            = PH_SEND_ACTIVE;
              st_next.send_start_stamp = now_ms;
            end
          end else if (fix_elapsed > cfg.fix_timeout_ms) begin
            end_c = 1'b1;
          end
        end
        PH_SEND_ACTIVE, PH_WAIT_REPLY: begin
          st_next.phase = PH_WAIT_REPLY;
          if (send_done || (send_elapsed > cfg.send_timeout_ms)) begin
            end_c = 1'b1;
          end
        end
        PH_COOLDOWN: begin
          if (!(cool_elapsed < cfg.cooldown_ms)) begin
            res.modem_reset = 1'b1;
            start_c         = 1'b1;
          end
        end
        PH_SLEEP: begin
          if (cfg.sleep_mode) begin
            if (motion_wake) begin
              res.motion_command = MOT_DISABLE;
              start_c            = 1'b1;
            end
          end else begin
            end_c = 1'b1;
          end
        end
        default: begin
          end_c = 1'b1;
        end
      endcase
    end

    if (end_c) begin
      res.receiver_power   = PWR_DISABLE;
      res.modem_power      = PWR_DISABLE;
      res.receiver_reset   = 1'b1;
      res.modem_reset      = 1'b1;
      st_next.fix_started  = 1'b0;
      st_next.send_started = 1'b0;
      if (cfg.sleep_mode) begin
        res.motion_command = MOT_LISTEN;
        st_next.phase      = PH_SLEEP;
      end else begin
        st_next.phase                = PH_COOLDOWN;
        st_next.cycle_count          = st.cycle_count + 32'd1;
        st_next.cooldown_start_stamp = now_ms;
      end
    end

    if (start_c) begin
      res.receiver_reset   = 1'b1;
      res.receiver_power   = PWR_ENABLE;
      res.apply_profile    = 1'b1;
      st_next.fix_started  = 1'b0;
      st_next.send_started = 1'b0;
      st_next.phase        = PH_FIX_ACTIVE;
    end

    res.phase       = st_next.phase;
    res.cycles_done = st_next.cycle_count;
  end

endmodule

// ===== rtl/core/fix_and_report_power_sequencer.sv =====
// Top level of the fix-and-report power sequencer: configuration registers,
// sequencer state and the result register. Depends on fnr_pkg and fnr_step.
//
// Each accepted step item is evaluated in the cycle it is accepted and its one
// result item appears in the result register on the next cycle; one item can be
// accepted every clock cycle, the rate being set by the combinational step logic
// and the one-deep result register, which accepts a new item in the same cycle
// that the waiting result is taken. mock_profile is held for the user of
// apply_profile and does not change the sequencing. No clearing pass after reset.
module fix_and_report_power_sequencer
  import fnr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     mode,
  input  logic [31:0]              now_ms,
  input  logic                     fix_ready,
  input  logic                     send_done,
  input  logic                     motion_wake,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               phase,
  output logic [1:0]               receiver_power,
  output logic                     receiver_reset,
  output logic [1:0]               modem_power,
  output logic                     modem_reset,
  output logic                     load_report,
  output logic [1:0]               motion_command,
  output logic                     apply_profile,
  output logic [31:0]              cycles_done
);

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  result_t res_next;
  result_t res;
  logic    accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  fnr_step u_step (
    .cfg         (cfg),
    .st          (st),
    .mode        (mode),
    .now_ms      (now_ms),
    .fix_ready   (fix_ready),
    .send_done   (send_done),
    .motion_wake (motion_wake),
    .st_next     (st_next),
    .res         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sleep_mode      <= 1'b0;
      cfg.mock_profile    <= 1'b0;
      cfg.fix_timeout_ms  <= FIX_TIMEOUT_RESET;
      cfg.send_timeout_ms <= SEND_TIMEOUT_RESET;
      cfg.cooldown_ms     <= COOLDOWN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLEEP_MODE:   cfg.sleep_mode      <= cfg_data[0];
        CFG_MOCK_PROFILE: cfg.mock_profile    <= cfg_data[0];
        CFG_FIX_TIMEOUT:  cfg.fix_timeout_ms  <= cfg_data;
        CFG_SEND_TIMEOUT: cfg.send_timeout_ms <= cfg_data;
        CFG_COOLDOWN:     cfg.cooldown_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase                <= PH_IDLE;
      st.fix_started          <= 1'b0;
      st.send_started         <= 1'b0;
      st.fix_start_stamp      <= '0;
      st.send_start_stamp     <= '0;
      st.cooldown_start_stamp <= '0;
      st.cycle_count          <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign phase          = res.phase;
  assign receiver_power = res.receiver_power;
  assign receiver_reset = res.receiver_reset;
  assign modem_power    = res.modem_power;
  assign modem_reset    = res.modem_reset;
  assign load_report    = res.load_report;
  assign motion_command = res.motion_command;
  assign apply_profile  = res.apply_profile;
  assign cycles_done    = res.cycles_done;

endmodule

// ===== rtl/core/fnr_checker.sv =====
// Port-level checks for the fix-and-report power sequencer, bound to the top level.
// Depends on fnr_pkg for the phase and command codes.
module fnr_checker
  import fnr_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [2:0]               phase,
  input logic [1:0]               receiver_power,
  input logic                     receiver_reset,
  input logic [1:0]               modem_power,
  input logic                     load_report,
  input logic                     apply_profile,
  input logic [31:0]              cycles_done
);

  // A result that is not taken stays as it was.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(cycles_done))
    else $error("result item changed while stalled");

  // Every accepted item yields a result on the next cycle.
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // The wait-fix code and code seven are never reported.
  a_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (phase != PH_WAIT_FIX) && (phase != 3'd7))
    else $error("unreachable phase reported");

  // Powering the receiver only happens as part of a fix start.
  a_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && (receiver_power == PWR_ENABLE) |->
      receiver_reset && apply_profile && (phase == PH_FIX_ACTIVE))
    else $error("receiver enabled outside a fix start");

  // Handing over the report always opens the send phase with the modem on.
  a_load: assert property (@(posedge clk) disable iff (rst)
    out_valid && load_report |-> (phase == PH_SEND_ACTIVE) && (modem_power == PWR_ENABLE))
    else $error("report handed over outside the send start");

endmodule

bind fix_and_report_power_sequencer fnr_checker u_fnr_checker (.*);

// ===== bench/fnr_step_checker.sv =====
// Step checker for the fix-and-report power sequencer: tracks register writes,
// predicts one result item per accepted step item and compares field by field.
// Depends on fnr_pkg for the phase, command and register codes.
module fnr_step_checker
  import fnr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     mode,
  input  logic [31:0]              now_ms,
  input  logic                     fix_ready,
  input  logic                     send_done,
  input  logic                     motion_wake,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [2:0]               phase,
  input  logic [1:0]               receiver_power,
  input  logic                     receiver_reset,
  input  logic [1:0]               modem_power,
  input  logic                     modem_reset,
  input  logic                     load_report,
  input  logic [1:0]               motion_command,
  input  logic                     apply_profile,
  input  logic [31:0]              cycles_done,
  output int                       fail_count,
  output int                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t        cfg_q;
  phase_t      ph_q;
  logic        fix_latched;
  logic        send_latched;
  logic [31:0] fix_stamp;
  logic [31:0] send_stamp;
  logic [31:0] cool_stamp;
  logic [31:0] cycle_q;
  result_t     expected_results[$];

  // Powers both parts down and resets them, then sleeps or starts the cooldown.
  function automatic void close_cycle(inout result_t r, input logic [31:0] t);
    r.receiver_power = PWR_DISABLE;
    r.modem_power    = PWR_DISABLE;
    r.receiver_reset = 1'b1;
    r.modem_reset    = 1'b1;
    fix_latched  = 1'b0;
    send_latched = 1'b0;
    if (cfg_q.sleep_mode) begin
      r.motion_command = MOT_LISTEN;
      ph_q = PH_SLEEP;
    end else begin
      ph_q       = PH_COOLDOWN;
      cycle_q    = cycle_q + 32'd1;
      cool_stamp = t;
    end
  endfunction

  function automatic void open_fix(inout result_t r);
    r.receiver_reset = 1'b1;
    r.receiver_power = PWR_ENABLE;
    r.apply_profile  = 1'b1;
    fix_latched  = 1'b0;
    send_latched = 1'b0;
    ph_q = PH_FIX_ACTIVE;
  endfunction

  function automatic result_t advance_sequencer(input logic m, input logic [31:0] t,
                                                input logic f, input logic d,
                                                input logic w);
    result_t     r;
    logic [31:0] elapsed;
    r = '0;
    if (m) begin
      fix_latched  = 1'b0;
      send_latched = 1'b0;
      if (cfg_q.sleep_mode) begin
        r.receiver_power = PWR_DISABLE;
        r.modem_power    = PWR_DISABLE;
        r.motion_command = MOT_INIT_LISTEN;
        ph_q = PH_SLEEP;
      end else begin
        r.motion_command = MOT_DISABLE;
        open_fix(r);
      end
    end else begin
      case (ph_q)
        PH_IDLE: begin
          if (cfg_q.sleep_mode) ph_q = PH_SLEEP;
          else ph_q = PH_FIX_ACTIVE;
        end
        PH_FIX_ACTIVE, PH_WAIT_FIX: begin
          if (!fix_latched) begin
            fix_latched = 1'b1;
            fix_stamp   = t;
          end
          elapsed = t - fix_stamp;
          if (f) begin
            // A fix while a send is already latched changes nothing.
            if (!send_latched) begin
              r.receiver_power = PWR_DISABLE;
              r.modem_power    = PWR_ENABLE;
              r.load_report    = 1'b1;
              send_latched = 1'b1;
              send_stamp   = t;
              ph_q = PH_SEND_ACTIVE;
            end
          end else if (elapsed > cfg_q.fix_timeout_ms) begin
            close_cycle(r, t);
          end
        end
        PH_SEND_ACTIVE, PH_WAIT_REPLY: begin
          ph_q = PH_WAIT_REPLY;
          elapsed = t - send_stamp;
          if (d || elapsed > cfg_q.send_timeout_ms) close_cycle(r, t);
        end
        PH_COOLDOWN: begin
          elapsed = t - cool_stamp;
          if (elapsed >= cfg_q.cooldown_ms) begin
            r.modem_reset = 1'b1;
            open_fix(r);
          end
        end
        PH_SLEEP: begin
          if (!cfg_q.sleep_mode) begin
            close_cycle(r, t);
          end else if (w) begin
            r.motion_command = MOT_DISABLE;
            open_fix(r);
          end
        end
        default: close_cycle(r, t);
      endcase
    end
    r.phase       = ph_q;
    r.cycles_done = cycle_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      cfg_q.sleep_mode      = 1'b0;
      cfg_q.mock_profile    = 1'b0;
      cfg_q.fix_timeout_ms  = FIX_TIMEOUT_RESET;
      cfg_q.send_timeout_ms = SEND_TIMEOUT_RESET;
      cfg_q.cooldown_ms     = COOLDOWN_RESET;
      ph_q         = PH_IDLE;
      fix_latched  = 1'b0;
      send_latched = 1'b0;
      fix_stamp    = '0;
      send_stamp   = '0;
      cool_stamp   = '0;
      cycle_q      = '0;
      expected_results.delete();
    end else begin
      // The result taken here belongs to an earlier step, so it is checked
      // before this edge's step item is predicted.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result item arrived with no step item waiting");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("phase", 32'(want.phase), 32'(phase));
          check_field("receiver_power", 32'(want.receiver_power), 32'(receiver_power));
          check_field("receiver_reset", 32'(want.receiver_reset), 32'(receiver_reset));
          check_field("modem_power", 32'(want.modem_power), 32'(modem_power));
          check_field("modem_reset", 32'(want.modem_reset), 32'(modem_reset));
          check_field("load_report", 32'(want.load_report), 32'(load_report));
          check_field("motion_command", 32'(want.motion_command), 32'(motion_command));
          check_field("apply_profile", 32'(want.apply_profile), 32'(apply_profile));
          check_field("cycles_done", want.cycles_done, cycles_done);
        end
      end
      // A register written at this edge only affects later step items.
      if (in_valid && in_ready) begin
        expected_results.push_back(advance_sequencer(mode, now_ms, fix_ready,
                                                     send_done, motion_wake));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLEEP_MODE:   cfg_q.sleep_mode      = cfg_data[0];
          CFG_MOCK_PROFILE: cfg_q.mock_profile    = cfg_data[0];
          CFG_FIX_TIMEOUT:  cfg_q.fix_timeout_ms  = cfg_data;
          CFG_SEND_TIMEOUT: cfg_q.send_timeout_ms = cfg_data;
          CFG_COOLDOWN:     cfg_q.cooldown_ms     = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== bench/tb.sv =====
// Top of the sequencer bench: clock, reset, register writes, step stimulus and
// a randomly stalling result receiver. Depends on fnr_pkg, the sequencer RTL
// and fnr_step_checker, which predicts and compares the result items.
module tb;
  import fnr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIndexWidth-1:0] CFG_UNUSED_INDEX = 3'd7;
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = 1'b0;
  logic [31:0] now_ms = '0;
  logic        fix_ready = 1'b0;
  logic        send_done = 1'b0;
  logic        motion_wake = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  phase;
  logic [1:0]  receiver_power;
  logic        receiver_reset;
  logic [1:0]  modem_power;
  logic        modem_reset;
  logic        load_report;
  logic [1:0]  motion_command;
  logic        apply_profile;
  logic [31:0] cycles_done;

  int          mismatches;
  int          outstanding;
  int          hold_requests = 0;
  int          stall_cycles = 0;
  logic        burst = 1'b0;
  logic        steady = 1'b0;
  logic [31:0] clock_ms;

  always #2 clk = ~clk;

  fix_and_report_power_sequencer dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .now_ms(now_ms), .fix_ready(fix_ready),
    .send_done(send_done), .motion_wake(motion_wake),
    .out_valid(out_valid), .out_ready(out_ready),
    .phase(phase), .receiver_power(receiver_power),
    .receiver_reset(receiver_reset), .modem_power(modem_power),
    .modem_reset(modem_reset), .load_report(load_report),
    .motion_command(motion_command), .apply_profile(apply_profile),
    .cycles_done(cycles_done)
  );

  fnr_step_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .now_ms(now_ms), .fix_ready(fix_ready),
    .send_done(send_done), .motion_wake(motion_wake),
    .out_valid(out_valid), .out_ready(out_ready),
    .phase(phase), .receiver_power(receiver_power),
    .receiver_reset(receiver_reset), .modem_power(modem_power),
    .modem_reset(modem_reset), .load_report(load_report),
    .motion_command(motion_command), .apply_profile(apply_profile),
    .cycles_done(cycles_done),
    .fail_count(mismatches), .outstanding(outstanding)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [31:0] pick_timeout(input int setting);
    int roll;
    roll = $urandom_range(0, 9);
    if (setting == 0) return 32'h0000_0000;
    if (setting == 1) return 32'hFFFF_FFFF;
    if (roll < 6) return $urandom_range(0, 40);
    if (roll == 6) return 32'h0000_0000;
    if (roll == 7) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_step(input logic m, input logic [31:0] t, input logic f,
                           input logic d, input logic w);
    int gap;
    gap = (burst || steady) ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    now_ms      <= t;
    fix_ready   <= f;
    send_done   <= d;
    motion_wake <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Registers may only change once every expected result item has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Receiver: random stalls, long ready runs, and one long hold-off on request.
  initial begin
    int served;
    served = 0;
    forever begin
      if (hold_requests > served) begin
        served++;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 60)) @(negedge clk);
        else repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: timeouts at and just past their limits, cooldown exactly met,
    // a fix window that wraps through zero, then sleep-mode operation.
    write_reg(CFG_SLEEP_MODE, 32'd0);
    write_reg(CFG_MOCK_PROFILE, 32'd1);
    write_reg(CFG_FIX_TIMEOUT, 32'd10);
    write_reg(CFG_SEND_TIMEOUT, 32'd5);
    write_reg(CFG_COOLDOWN, 32'd20);
    write_reg(CFG_UNUSED_INDEX, $urandom());
    send_step(1'b0, 32'd100, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 32'd100, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 32'd110, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 32'd111, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 32'd130, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 32'd131, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 32'd131, 1'b1, 1'b0, 1'b0);
    send_step(1'b0, 32'd136, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 32'd137, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 32'hFFFF_FFF8, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 32'h0000_0002, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 32'h0000_0003, 1'b1, 1'b1, 1'b1);
    send_step(1'b0, 32'h0000_0004, 1'b0, 1'b1, 1'b0);
    wait_drained();
    write_reg(CFG_SLEEP_MODE, 32'd1);
    write_reg(CFG_FIX_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(CFG_SEND_TIMEOUT, 32'd0);
    write_reg(CFG_COOLDOWN, 32'd0);
    send_step(1'b1, 32'h8000_0000, 1'b1, 1'b1, 1'b1);
    send_step(1'b0, 32'h8000_0001, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 32'h8000_0002, 1'b0, 1'b0, 1'b1);
    send_step(1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    send_step(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
    wait_drained();
    // A sleeping block switched to periodic mode ends the cycle on the next step.
    write_reg(CFG_SLEEP_MODE, 32'd0);
    send_step(1'b0, 32'h1234_5678, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 32'h1234_5678, 1'b0, 1'b0, 1'b0);

    // Random: mostly well-formed sequences with slowly rising time and small
    // timeouts, plus noise steps with arbitrary fields.
    clock_ms = $urandom();
    for (int s = 0; s < 8; s++) begin
      wait_drained();
      write_reg(CFG_SLEEP_MODE, $urandom());
      write_reg(CFG_MOCK_PROFILE, $urandom());
      write_reg(CFG_FIX_TIMEOUT, pick_timeout(s));
      write_reg(CFG_SEND_TIMEOUT, pick_timeout(s));
      write_reg(CFG_COOLDOWN, pick_timeout(s));
      if ($urandom_range(0, 3) == 0) clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 200);
      steady = 1'b0;
      for (int k = 0; k < 200; k++) begin
        if (k % 50 == 0) steady = ($urandom_range(0, 3) == 0);
        burst = (s == 3 && k < 150);
        // The receiver holds off while the sender keeps offering step items.
        if (s == 3 && k == 0) hold_requests++;
        if ($urandom_range(0, 9) == 0) begin
          send_step(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          clock_ms = clock_ms + $urandom_range(0, 12);
          send_step($urandom_range(0, 99) < 3, clock_ms, $urandom_range(0, 99) < 20,
                    $urandom_range(0, 99) < 20, $urandom_range(0, 99) < 25);
        end
      end
    end
    burst = 1'b0;
    wait_drained();
    repeat (5) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== fix_and_report_power_sequencer.f =====
rtl/core/fnr_pkg.sv
rtl/core/fnr_step.sv
rtl/core/fix_and_report_power_sequencer.sv
rtl/core/fnr_checker.sv
bench/fnr_step_checker.sv
bench/tb.sv
